/* src/tbo_pkg.sv */
package tbo_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned NUM_REGS        = 6;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned NUM_AXIS        = 9;

  // register indexes of the box corners
  localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Z = 3'd5;

  // vertex pair projected by each edge-cross-axis test
  localparam int unsigned AXIS_VA [NUM_AXIS] = '{0, 0, 1, 0, 0, 0, 0, 0, 1};
  localparam int unsigned AXIS_VB [NUM_AXIS] = '{2, 2, 2, 2, 2, 1, 1, 1, 2};

  // per-stage advance enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stg_en_t;

endpackage

/* src/tbo_prep.sv */
module tbo_prep import tbo_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  stg_en_t                         en,
  input  logic [9*COORD_WIDTH-1:0]        vert,
  input  logic signed [COORD_WIDTH-1:0]   bmin [3],
  input  logic signed [COORD_WIDTH-1:0]   bmax [3],
  output logic signed [COORD_WIDTH+1:0]   v_r [3][3],
  output logic signed [COORD_WIDTH+1:0]   e_r [3][3],
  output logic signed [COORD_WIDTH:0]     h_r [3]
);

  localparam int unsigned VW = COORD_WIDTH + 2;
  localparam int unsigned HW = COORD_WIDTH + 1;

  logic signed [VW-1:0] v_nxt [3][3];
  logic signed [VW-1:0] e_nxt [3][3];
  logic signed [HW-1:0] h_nxt [3];

  // doubled coordinates relative to twice the box centre
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        v_nxt[k][i] = (VW'($signed(vert[(k*3+i)*COORD_WIDTH +: COORD_WIDTH])) <<< 1)
                    - (VW'(bmin[i]) + VW'(bmax[i]));
      end
    end
    for (int i = 0; i < 3; i++) begin
      h_nxt[i]    = HW'(bmax[i]) - HW'(bmin[i]);
      e_nxt[0][i] = v_nxt[1][i] - v_nxt[0][i];
      e_nxt[1][i] = v_nxt[2][i] - v_nxt[1][i];
      e_nxt[2][i] = v_nxt[0][i] - v_nxt[2][i];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      v_r <= v_nxt;
      e_r <= e_nxt;
      h_r <= h_nxt;
    end
  end

endmodule

/* src/tbo_axis.sv */
module tbo_axis import tbo_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  stg_en_t                       en,
  input  logic signed [COORD_WIDTH+1:0] a,
  input  logic signed [COORD_WIDTH+1:0] b,
  input  logic signed [COORD_WIDTH+1:0] u0,
  input  logic signed [COORD_WIDTH+1:0] w0,
  input  logic signed [COORD_WIDTH+1:0] u1,
  input  logic signed [COORD_WIDTH+1:0] w1,
  input  logic signed [COORD_WIDTH:0]   hu,
  input  logic signed [COORD_WIDTH:0]   hw,
  output logic                          sep_r
);

  localparam int unsigned AW = COORD_WIDTH + 3;
  localparam int unsigned PW = 2*COORD_WIDTH + 4;
  localparam int unsigned SW = 2*COORD_WIDTH + 6;

  logic signed [AW-1:0] a_ext, b_ext, a_abs, b_abs;
  logic signed [PW-1:0] au0_r, bw0_r, au1_r, bw1_r, ra_r, rb_r;
  logic signed [SW-1:0] p0_r, p1_r, rad_r, lo, hi;
  logic                 sep_nxt;

  always_comb begin
    a_ext = AW'(a);
    b_ext = AW'(b);
    a_abs = (a_ext < 0) ? -a_ext : a_ext;
    b_abs = (b_ext < 0) ? -b_ext : b_ext;
  end

  // products
  always_ff @(posedge clk) begin
    if (en.s2) begin
      au0_r <= PW'(a) * PW'(u0);
      bw0_r <= PW'(b) * PW'(w0);
      au1_r <= PW'(a) * PW'(u1);
      bw1_r <= PW'(b) * PW'(w1);
      ra_r  <= PW'(a_abs) * PW'(hu);
      rb_r  <= PW'(b_abs) * PW'(hw);
    end
  end

  // projections and radius
  always_ff @(posedge clk) begin
    if (en.s3) begin
      p0_r  <= SW'(au0_r) - SW'(bw0_r);
      p1_r  <= SW'(au1_r) - SW'(bw1_r);
      rad_r <= SW'(ra_r) + SW'(rb_r);
    end
  end

  always_comb begin
    lo      = (p1_r > p0_r) ? p0_r : p1_r;
    hi      = (p1_r > p0_r) ? p1_r : p0_r;
    sep_nxt = (lo > rad_r) || (-rad_r > hi);
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      sep_r <= sep_nxt;
    end
  end

endmodule

/* src/tbo_plane.sv */
module tbo_plane import tbo_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  stg_en_t                       en,
  input  logic signed [COORD_WIDTH+1:0] v [3][3],
  input  logic signed [COORD_WIDTH+1:0] e [3][3],
  input  logic signed [COORD_WIDTH:0]   h [3],
  output logic                          pass_r
);

  localparam int unsigned VW = COORD_WIDTH + 2;
  localparam int unsigned CW = COORD_WIDTH + 3;
  localparam int unsigned PW = 2*COORD_WIDTH + 4;
  localparam int unsigned NW = 2*COORD_WIDTH + 5;
  localparam int unsigned MW = 3*COORD_WIDTH + 8;
  localparam int unsigned DW = 3*COORD_WIDTH + 10;

  logic signed [PW-1:0] np_r [3][2];
  logic signed [CW-1:0] pos2_r [3], neg2_r [3], pos3_r [3], neg3_r [3];
  logic signed [NW-1:0] n_r [3];
  logic signed [MW-1:0] mmin_r [3], mmax_r [3];
  logic                 ext2_r, ext3_r, ext4_r;
  logic signed [CW-1:0] mn [3], mx [3];
  logic                 ext_nxt;
  logic signed [DW-1:0] dmin, dmax;

  // extents of the triangle against the box
  always_comb begin
    ext_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      mn[i] = CW'(v[0][i]);
      mx[i] = CW'(v[0][i]);
      for (int k = 1; k < 3; k++) begin
        if (CW'(v[k][i]) < mn[i]) mn[i] = CW'(v[k][i]);
        if (CW'(v[k][i]) > mx[i]) mx[i] = CW'(v[k][i]);
      end
      ext_nxt = ext_nxt | (mn[i] > CW'(h[i])) | (-CW'(h[i]) > mx[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      np_r[0][0] <= PW'(e[0][1]) * PW'(e[1][2]);
      np_r[0][1] <= PW'(e[0][2]) * PW'(e[1][1]);
      np_r[1][0] <= PW'(e[0][2]) * PW'(e[1][0]);
      np_r[1][1] <= PW'(e[0][0]) * PW'(e[1][2]);
      np_r[2][0] <= PW'(e[0][0]) * PW'(e[1][1]);
      np_r[2][1] <= PW'(e[0][1]) * PW'(e[1][0]);
      for (int i = 0; i < 3; i++) begin
        pos2_r[i] <= CW'(h[i]) - CW'(v[0][i]);
        neg2_r[i] <= -CW'(h[i]) - CW'(v[0][i]);
      end
      ext2_r <= ext_nxt;
    end
  end

  // plane normal
  always_ff @(posedge clk) begin
    if (en.s3) begin
      for (int i = 0; i < 3; i++) begin
        n_r[i] <= NW'(np_r[i][0]) - NW'(np_r[i][1]);
      end
      pos3_r <= pos2_r;
      neg3_r <= neg2_r;
      ext3_r <= ext2_r;
    end
  end

  // normal against nearest and farthest box corner
  always_ff @(posedge clk) begin
    if (en.s4) begin
      for (int i = 0; i < 3; i++) begin
        mmin_r[i] <= MW'(n_r[i]) * MW'((n_r[i] > 0) ? neg3_r[i] : pos3_r[i]);
        mmax_r[i] <= MW'(n_r[i]) * MW'((n_r[i] > 0) ? pos3_r[i] : neg3_r[i]);
      end
      ext4_r <= ext3_r;
    end
  end

  always_comb begin
    dmin = DW'(mmin_r[0]) + DW'(mmin_r[1]) + DW'(mmin_r[2]);
    dmax = DW'(mmax_r[0]) + DW'(mmax_r[1]) + DW'(mmax_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      pass_r <= !ext4_r && !(dmin > 0) && (dmax >= 0);
    end
  end

endmodule

/* src/triangle_box_overlap_test_top.sv */
// channel  | direction | payload
// in_      | slave     | tdata: vert0_x, vert0_y, vert0_z, vert1_x .. vert2_z
// out_     | master    | tdata: overlaps
// cfg_     | slave     | index selects box_min_x..box_max_z, data is the value
//
// one triangle per cycle sustained while out_ is ready; each result passes through all
// five register stages: vertex prep, products, sums, compares and plane products, result
// a stall on out_ holds only the stages that are full, so bubbles still fill up
// rst_n clears the valid bits and the box to zero; cfg_ready is always high
module triangle_box_overlap_test_top import tbo_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z, vert2_x, vert2_y, vert2_z
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]   in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // overlaps
  output logic [7:0]                           out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [CFG_IDX_W-1:0]                 cfg_index,
  input  logic [COORD_WIDTH-1:0]               cfg_data
);

  logic signed [COORD_WIDTH-1:0] bmin_r [3];
  logic signed [COORD_WIDTH-1:0] bmax_r [3];
  logic                          v1_r, v2_r, v3_r, v4_r, v5_r;
  stg_en_t                       en;
  logic signed [COORD_WIDTH+1:0] v_r [3][3];
  logic signed [COORD_WIDTH+1:0] e_r [3][3];
  logic signed [COORD_WIDTH:0]   h_r [3];
  logic [NUM_AXIS-1:0]           sep;
  logic                          sep5_r;
  logic                          pass_r;

  assign cfg_ready = 1'b1;

  // box registers, out-of-range index ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        bmin_r[i] <= '0;
        bmax_r[i] <= '0;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MIN_X: bmin_r[0] <= cfg_data;
        REG_MIN_Y: bmin_r[1] <= cfg_data;
        REG_MIN_Z: bmin_r[2] <= cfg_data;
        REG_MAX_X: bmax_r[0] <= cfg_data;
        REG_MAX_Y: bmax_r[1] <= cfg_data;
        REG_MAX_Z: bmax_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stage advances when it is empty or the next one advances
  always_comb begin
    en.s5 = !v5_r || out_tready;
    en.s4 = !v4_r || en.s5;
    en.s3 = !v3_r || en.s4;
    en.s2 = !v2_r || en.s3;
    en.s1 = !v1_r || en.s2;
  end

  assign in_tready = en.s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en.s1) v1_r <= in_tvalid;
      if (en.s2) v2_r <= v1_r;
      if (en.s3) v3_r <= v2_r;
      if (en.s4) v4_r <= v3_r;
      if (en.s5) v5_r <= v4_r;
    end
  end

  tbo_prep #(.COORD_WIDTH(COORD_WIDTH)) u_prep (
    .clk  (clk),
    .en   (en),
    .vert (in_tdata[9*COORD_WIDTH-1:0]),
    .bmin (bmin_r),
    .bmax (bmax_r),
    .v_r  (v_r),
    .e_r  (e_r),
    .h_r  (h_r)
  );

  // edge k crossed with axis j
  for (genvar t = 0; t < NUM_AXIS; t++) begin : g_axis
    localparam int unsigned K  = t / 3;
    localparam int unsigned J  = t % 3;
    localparam int unsigned C1 = (J + 1) % 3;
    localparam int unsigned C2 = (J + 2) % 3;
    tbo_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis (
      .clk   (clk),
      .en    (en),
      .a     (e_r[K][C2]),
      .b     (e_r[K][C1]),
      .u0    (v_r[AXIS_VA[t]][C1]),
      .w0    (v_r[AXIS_VA[t]][C2]),
      .u1    (v_r[AXIS_VB[t]][C1]),
      .w1    (v_r[AXIS_VB[t]][C2]),
      .hu    (h_r[C1]),
      .hw    (h_r[C2]),
      .sep_r (sep[t])
    );
  end

  tbo_plane #(.COORD_WIDTH(COORD_WIDTH)) u_plane (
    .clk    (clk),
    .en     (en),
    .v      (v_r),
    .e      (e_r),
    .h      (h_r),
    .pass_r (pass_r)
  );

  always_ff @(posedge clk) begin
    if (en.s5) begin
      sep5_r <= |sep;
    end
  end

  assign out_tvalid = v5_r;
  assign out_tdata  = {7'b0, pass_r & !sep5_r};

  // an empty output stage never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready) else $error("input blocked with empty output");

  // a held result stays valid
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped under stall");

  // an accepted triangle enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v1_r) else $error("transfer lost at entry");

  // a full pipeline with a stalled output refuses input
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && v2_r && v3_r && v4_r && v5_r && !out_tready |-> !in_tready)
    else $error("input taken while pipeline full");

endmodule
